// File: rtl/core/lcpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcpg_pkg: shared types and constants for the linear chirp period generator
// Field widths, clamp limits, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package lcpg_pkg;

  // field widths
  localparam int FREQ_W   = 20;
  localparam int DUR_W    = 19;
  localparam int IDX_W    = 16;
  localparam int STEPS_W  = 17;
  localparam int RELOAD_W = 16;

  // clamp limits
  localparam int FREQ_MIN_HZ     = 4000;
  localparam int FREQ_MAX_HZ     = 500000;
  localparam int DURATION_MIN_US = 100;
  localparam int STEPS_MAX       = 65536;

  // quotient bits of (hi - lo) / duration: below FREQ_MAX_HZ / DURATION_MIN_US
  localparam int SLOPE_Q_W = $clog2(FREQ_MAX_HZ / DURATION_MIN_US + 1);

  // register reset values
  localparam int START_FREQ_RST = 10000;
  localparam int STOP_FREQ_RST  = 200000;
  localparam int DURATION_RST   = 1000;

  // config register indexes
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_START_FREQ = 2'd0;
  localparam cfg_idx_t CFG_STOP_FREQ  = 2'd1;
  localparam cfg_idx_t CFG_DURATION   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_RLD,
    ST_PUSH
  } state_t;

endpackage

// File: rtl/core/lcpg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcpg_div: bit-serial restoring divider
// One quotient bit per cycle. The dividend bits above Q_W are
// preloaded as partial remainder and must be below the divisor.
// ----------------------------------------------------------------------------
module lcpg_div #(
  parameter int DVD_W = 20,
  parameter int DVS_W = 19,
  parameter int Q_W   = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [Q_W-1:0]   quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(Q_W);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic             q_bit;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial   = {rem_r, q_r[Q_W-1]} - {1'b0, dvs_r};
    q_bit   = ~trial[DVS_W];
    rem_nxt = q_bit ? trial[DVS_W-1:0] : {rem_r[DVS_W-2:0], q_r[Q_W-1]};
    q_nxt   = {q_r[Q_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DVS_W'(dividend >> Q_W);
      q_r   <= dividend[Q_W-1:0];
      dvs_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(Q_W - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(Q_W - 1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

// File: rtl/core/lcpg_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcpg_mul: bit-serial shift-add multiplier
// Walks the step index MSB first, one bit per cycle. The product is known to
// stay within the frequency width, so the accumulator is that narrow.
// ----------------------------------------------------------------------------
module lcpg_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lcpg_pkg::FREQ_W-1:0] mcand,
  input  logic [lcpg_pkg::IDX_W-1:0]  mplier,
  output logic [lcpg_pkg::FREQ_W-1:0] product,
  output logic                        done
);

  import lcpg_pkg::*;

  localparam int CNT_W = $clog2(IDX_W);

  logic [FREQ_W-1:0] mcand_r;
  logic [FREQ_W-1:0] acc_r, acc_nxt;
  logic [IDX_W-1:0]  mpl_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  always_comb begin
    acc_nxt = {acc_r[FREQ_W-2:0], 1'b0} + (mpl_r[IDX_W-1] ? mcand_r : '0);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      mpl_r   <= mplier;
      acc_r   <= '0;
      cnt_r   <= '0;
    end else if (busy_r) begin
      acc_r   <= acc_nxt;
      mpl_r   <= {mpl_r[IDX_W-2:0], 1'b0};
      cnt_r   <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(IDX_W - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(IDX_W - 1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign product = acc_r;
  assign done    = done_r;

endmodule

// File: rtl/core/linear_chirp_period_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_chirp_period_generator: timer values for one step of a linear sweep
// Per tick beat: reload = TIMER_CLOCK_HZ / (slope * STEP_US * index + lo_c),
// compare = reload / 2, with step index, last-step flag and index wrap.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------
//  in_     | in  | in_valid / in_stall  | in_restart
//  out_    | out | out_valid / out_stall| out_reload_value, out_compare_value,
//          |     |                      | out_step_number, out_last_step
//  cfg_    | in  | cfg_we               | cfg_index, cfg_data
//
//  Sequence: one beat at a time. A beat runs the steps and slope divides,
//    then the index multiply, then the reload divide, all bit-serial (16-bit
//    steps divide, 16-bit index multiply, 16-bit reload divide); a new beat
//    is taken only after the result has been handed to the output
//    register.
//  Slope and step-count divides run side by side; the step-count divide
//    sets the first phase.
//  Reset: synchronous rst_n clears control state and loads the register
//    defaults (10000 Hz, 200000 Hz, 1000 us), sweep index zero.
//  Stalls: the result sits in an output register, so a new beat is taken
//    while out_stall holds the previous one; the finished beat waits in
//    ST_PUSH only if the output register is still occupied.
//
// ----------------------------------------------------------------------------
module linear_chirp_period_generator #(
  parameter int TIMER_CLOCK_HZ = 168000000,
  parameter int STEP_US        = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_we,
  input  lcpg_pkg::cfg_idx_t            cfg_index,
  input  logic [lcpg_pkg::FREQ_W-1:0]   cfg_data,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_restart,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lcpg_pkg::RELOAD_W-1:0] out_reload_value,
  output logic [lcpg_pkg::RELOAD_W-2:0] out_compare_value,
  output logic [lcpg_pkg::IDX_W-1:0]    out_step_number,
  output logic                          out_last_step
);

  import lcpg_pkg::*;

  // steps divide: duration / STEP_US over the full register range
  localparam int STP_W     = $clog2(STEP_US + 1);
  localparam int STP_Q_W   = $clog2(((2 ** DUR_W) - 1) / STEP_US + 1);
  localparam int STP_EXT_W = (STP_Q_W > STEPS_W) ? STP_Q_W : STEPS_W;
  // reload divide: quotient bounded by TIMER_CLOCK_HZ / FREQ_MIN_HZ
  localparam int TCK_W     = $clog2(TIMER_CLOCK_HZ + 1);
  localparam int RLD_Q_W   = $clog2(TIMER_CLOCK_HZ / FREQ_MIN_HZ + 1);
  localparam int RLD_EXT_W = (RLD_Q_W > RELOAD_W) ? RLD_Q_W : RELOAD_W;
  // slope times step length
  localparam int MC_W      = SLOPE_Q_W + STP_W;

  // config registers
  logic [FREQ_W-1:0] start_freq_r;
  logic [FREQ_W-1:0] stop_freq_r;
  logic [DUR_W-1:0]  duration_r;

  // ordered and clamped sweep limits
  logic [FREQ_W-1:0] lo_c, hi_c, diff_c;
  logic [DUR_W-1:0]  dur_c;

  state_t state_r, state_nxt;

  logic              restart_r;
  logic [IDX_W-1:0]  sweep_index_r;
  logic [IDX_W-1:0]  idx_r;
  logic              last_r;
  logic              slope_done_r;
  logic              steps_done_r;

  logic              in_accept;
  logic              div_start, mul_start, rld_start, out_load;

  logic [SLOPE_Q_W-1:0] slope_q;
  logic                 slope_done;
  logic [STP_Q_W-1:0]   steps_q;
  logic                 steps_done;
  logic [FREQ_W-1:0]    mul_prod;
  logic                 mul_done;
  logic [RLD_Q_W-1:0]   rld_q;
  logic                 rld_done;

  logic [STP_EXT_W-1:0] steps_ext;
  logic [STEPS_W-1:0]   steps_c;
  logic [IDX_W-1:0]     idx_raw, idx_c;
  logic                 last_c;
  logic [MC_W-1:0]      mcand_full;
  logic [FREQ_W-1:0]    freq_c;
  logic [RLD_EXT_W-1:0] rld_ext;
  logic [RELOAD_W-1:0]  reload_c;

  logic                 out_valid_r;
  logic [RELOAD_W-1:0]  out_reload_r;
  logic [IDX_W-1:0]     out_step_r;
  logic                 out_last_r;

  // -------- config port --------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_freq_r <= FREQ_W'(START_FREQ_RST);
      stop_freq_r  <= FREQ_W'(STOP_FREQ_RST);
      duration_r   <= DUR_W'(DURATION_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_FREQ: start_freq_r <= cfg_data;
        CFG_STOP_FREQ:  stop_freq_r  <= cfg_data;
        CFG_DURATION:   duration_r   <= cfg_data[DUR_W-1:0];
        default:        ;
      endcase
    end
  end

  // order, clamp; hi below lo after clamping gives a flat sweep
  always_comb begin
    lo_c = (start_freq_r > stop_freq_r) ? stop_freq_r : start_freq_r;
    hi_c = (start_freq_r > stop_freq_r) ? start_freq_r : stop_freq_r;
    if (lo_c <= FREQ_W'(FREQ_MIN_HZ)) begin
      lo_c = FREQ_W'(FREQ_MIN_HZ);
    end
    if (hi_c >= FREQ_W'(FREQ_MAX_HZ)) begin
      hi_c = FREQ_W'(FREQ_MAX_HZ);
    end
    diff_c = (hi_c > lo_c) ? (hi_c - lo_c) : '0;
    dur_c  = (duration_r <= DUR_W'(DURATION_MIN_US)) ? DUR_W'(DURATION_MIN_US)
                                                     : duration_r;
  end

  // -------- arithmetic units --------
  lcpg_div #(
    .DVD_W (FREQ_W),
    .DVS_W (DUR_W),
    .Q_W   (SLOPE_Q_W)
  ) u_slope_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_c),
    .divisor  (dur_c),
    .quotient (slope_q),
    .done     (slope_done)
  );

  lcpg_div #(
    .DVD_W (DUR_W),
    .DVS_W (STP_W),
    .Q_W   (STP_Q_W)
  ) u_steps_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dur_c),
    .divisor  (STP_W'(STEP_US)),
    .quotient (steps_q),
    .done     (steps_done)
  );

  // step count: at least one, at most 65536
  always_comb begin
    steps_ext = STP_EXT_W'(steps_q);
    if (steps_ext == '0) begin
      steps_c = STEPS_W'(1);
    end else if (steps_ext > STP_EXT_W'(STEPS_MAX)) begin
      steps_c = STEPS_W'(STEPS_MAX);
    end else begin
      steps_c = STEPS_W'(steps_ext);
    end
  end

  // index of this beat; out-of-range index falls back to step zero
  always_comb begin
    idx_raw = restart_r ? '0 : sweep_index_r;
    idx_c   = ({1'b0, idx_raw} >= steps_c) ? '0 : idx_raw;
    last_c  = (({1'b0, idx_c} + STEPS_W'(1)) == steps_c);
  end

  assign mcand_full = MC_W'(slope_q) * MC_W'(STEP_US);

  lcpg_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (FREQ_W'(mcand_full)),
    .mplier  (idx_r),
    .product (mul_prod),
    .done    (mul_done)
  );

  // sweep offset never exceeds diff_c, so this stays at or below hi unless hi is below lo
  assign freq_c = mul_prod + lo_c;

  lcpg_div #(
    .DVD_W (TCK_W),
    .DVS_W (FREQ_W),
    .Q_W   (RLD_Q_W)
  ) u_rld_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rld_start),
    .dividend (TCK_W'(TIMER_CLOCK_HZ)),
    .divisor  (freq_c),
    .quotient (rld_q),
    .done     (rld_done)
  );

  always_comb begin
    rld_ext  = RLD_EXT_W'(rld_q);
    reload_c = (rld_ext > RLD_EXT_W'((2 ** RELOAD_W) - 1)) ? '1
                                                         : RELOAD_W'(rld_ext);
  end

  // -------- sequencer --------
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    mul_start = 1'b0;
    rld_start = 1'b0;
    out_load  = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if ((slope_done_r || slope_done) && (steps_done_r || steps_done)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // first cycle here starts the multiply from the latched index
        mul_start = !slope_done_r;
        if (mul_done) begin
          rld_start = 1'b1;
          state_nxt = ST_RLD;
        end
      end
      ST_RLD: begin
        if (rld_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // divide-done flags, restart latch and sweep index advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_done_r  <= 1'b0;
      steps_done_r  <= 1'b0;
      sweep_index_r <= '0;
      restart_r     <= 1'b0;
    end else begin
      if (in_accept) begin
        restart_r    <= in_restart;
        slope_done_r <= 1'b0;
        steps_done_r <= 1'b0;
      end else if (state_r == ST_DIV) begin
        if (state_nxt == ST_MUL) begin
          // clear so the first multiply cycle sees it low
          slope_done_r  <= 1'b0;
          sweep_index_r <= last_c ? '0 : (idx_c + IDX_W'(1));
        end else if (slope_done) begin
          slope_done_r <= 1'b1;
        end
        if (steps_done) begin
          steps_done_r <= 1'b1;
        end
      end else if (mul_start) begin
        // reuse the flag so the multiply starts once
        slope_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DIV) && (state_nxt == ST_MUL)) begin
      idx_r  <= idx_c;
      last_r <= last_c;
    end
  end

  // -------- output register --------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reload_r <= reload_c;
      out_step_r   <= idx_r;
      out_last_r   <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reload_value  = out_reload_r;
  assign out_compare_value = out_reload_r[RELOAD_W-1:1];
  assign out_step_number   = out_step_r;
  assign out_last_step     = out_last_r;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for linear_chirp_period_generator
// Sends tick beats in random bursts and reprograms the sweep registers between
// phases. A scoreboard computes each expected step and compares it field by
// field with what comes out.
// ----------------------------------------------------------------------------
module testbench;
  import lcpg_pkg::*;

  localparam int TIMER_CLOCK_HZ = 168000000;
  localparam int STEP_US        = 10;

  // Drain with some margin after the last step is back.
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_TICKS   = 1000;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Index past the register list; the block must ignore writes to it.
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  // One step of the sweep as it leaves the block.
  typedef struct packed {
    logic [RELOAD_W-1:0] reload;
    logic [RELOAD_W-2:0] compare;
    logic [IDX_W-1:0]    step;
    logic                last;
  } chirp_step_t;

  // Receiver stall behavior, changed at random intervals.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_t;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the sweep registers and the step index,
  // predicts one step per accepted tick and checks results in order.
  // --------------------------------------------------------------------------
  class chirp_scoreboard;
    logic [FREQ_W-1:0] start_hz;
    logic [FREQ_W-1:0] stop_hz;
    logic [DUR_W-1:0]  dur_us;
    logic [IDX_W-1:0]  step_idx;
    chirp_step_t       expected_steps[$];
    int                errors;

    function new();
      start_hz = FREQ_W'(START_FREQ_RST);
      stop_hz  = FREQ_W'(STOP_FREQ_RST);
      dur_us   = DUR_W'(DURATION_RST);
      step_idx = '0;
      errors   = 0;
    endfunction

    // Register write; duration keeps only its low DUR_W bits.
    function void write_reg(cfg_idx_t idx, logic [FREQ_W-1:0] data);
      case (idx)
        CFG_START_FREQ: start_hz = data;
        CFG_STOP_FREQ:  stop_hz  = data;
        CFG_DURATION:   dur_us   = data[DUR_W-1:0];
        default: ;
      endcase
    endfunction

    // Accepted tick: work out the step it produces and advance the index.
    function void note_tick(logic restart);
      longint unsigned lo, hi, dur, slope, n_steps, freq, quot;
      logic [IDX_W-1:0] cur;
      chirp_step_t e;
      lo  = 64'(start_hz);
      hi  = 64'(stop_hz);
      dur = 64'(dur_us);
      if (lo > hi) begin
        slope = lo;
        lo = hi;
        hi = slope;
      end
      if (lo < FREQ_MIN_HZ) lo = 64'(FREQ_MIN_HZ);
      if (hi > FREQ_MAX_HZ) hi = 64'(FREQ_MAX_HZ);
      if (dur < DURATION_MIN_US) dur = 64'(DURATION_MIN_US);
      // both ends above the max clamp or below the min clamp: hi lands below lo, flat sweep
      slope = (hi > lo) ? (hi - lo) / dur : 0;
      n_steps = dur / STEP_US;
      if (n_steps == 0) n_steps = 1;
      if (n_steps > STEPS_MAX) n_steps = 64'(STEPS_MAX);
      if (restart) step_idx = '0;
      cur = step_idx;
      // sweep shortened under a running index: take it as step zero
      if (cur >= n_steps) cur = '0;
      freq = slope * STEP_US * cur + lo;
      quot = TIMER_CLOCK_HZ / freq;
      if (quot > 64'hFFFF) quot = 64'hFFFF;
      e.reload  = quot[RELOAD_W-1:0];
      e.compare = e.reload[RELOAD_W-1:1];
      e.step    = cur;
      e.last    = (cur + 1 == n_steps);
      step_idx  = e.last ? '0 : cur + 1'b1;
      expected_steps.push_back(e);
    endfunction

    function void check_result(chirp_step_t got);
      chirp_step_t e;
      if (expected_steps.size() == 0) begin
        if (errors < 10)
          $display("%0t: unexpected step: reload=%0d compare=%0d step=%0d last=%0d",
                   $realtime, got.reload, got.compare, got.step, got.last);
        errors++;
      end else begin
        e = expected_steps.pop_front();
        if (got !== e) begin
          if (errors < 10)
            $display({"%0t: step mismatch: expected reload=%0d compare=%0d step=%0d ",
                      "last=%0d, got reload=%0d compare=%0d step=%0d last=%0d"},
                     $realtime, e.reload, e.compare, e.step, e.last,
                     got.reload, got.compare, got.step, got.last);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [FREQ_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic in_restart;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RELOAD_W-1:0] out_reload_value;
  logic [RELOAD_W-2:0] out_compare_value;
  logic [IDX_W-1:0]    out_step_number;
  logic                out_last_step;

  chirp_scoreboard sb = new();

  linear_chirp_period_generator #(
    .TIMER_CLOCK_HZ(TIMER_CLOCK_HZ),
    .STEP_US       (STEP_US)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reload_value (out_reload_value),
    .out_compare_value(out_compare_value),
    .out_step_number  (out_step_number),
    .out_last_step    (out_last_step)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Monitor. Reads run in the active region right after the edge, so they see
  // pre-edge values: exactly what the DUT saw when it took the beat.
  // Input first, so a tick is always predicted before its result is checked.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    chirp_step_t got;
    if (rst_n && in_valid && !in_stall)
      sb.note_tick(in_restart);
    if (rst_n && out_valid && !out_stall) begin
      got.reload  = out_reload_value;
      got.compare = out_compare_value;
      got.step    = out_step_number;
      got.last    = out_last_step;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure: free-flowing, light or heavy stall stretches,
  // each lasting a random number of cycles.
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_mode_left = 0;

  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      <= stall_mode_t'($urandom_range(0, 2));
      stall_mode_left <= $urandom_range(50, 500);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      default:     out_stall <= ($urandom_range(0, 99) < 90);
    endcase
  end

  // Watchdog
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------

  // One register write per cycle; cfg_we stays high across back-to-back
  // writes and is dropped by cfg_release.
  task automatic cfg_write(cfg_idx_t idx, logic [FREQ_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_release();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Present one tick beat and hold it until taken. Valid is left high so the
  // next call can follow without a bubble.
  task automatic send_tick(logic restart);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic stop_ticks();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Bursty tick stream; restart_pct sets how often a beat restarts the sweep.
  task automatic run_ticks(int n, int restart_pct);
    int burst_left;
    int gap;
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 80);
        if (gap > 0) begin
          in_valid   <= 1'b0;
          in_restart <= 1'($urandom_range(0, 1));   // ignored while idle
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 30);
      end
      send_tick($urandom_range(0, 99) < restart_pct);
      burst_left--;
    end
    stop_ticks();
  endtask

  // Idle point for register writes: every step is back and the last beat
  // has cleared the pipeline.
  task automatic wait_drained();
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Frequencies spread over the low clamp, the useful band, the high clamp
  // and the full 20-bit range.
  function automatic logic [FREQ_W-1:0] pick_freq();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20)      return FREQ_W'($urandom_range(0, 20'hFFFFF));
    else if (r < 35) return FREQ_W'($urandom_range(0, FREQ_MIN_HZ));
    else if (r < 85) return FREQ_W'($urandom_range(FREQ_MIN_HZ, FREQ_MAX_HZ));
    else             return FREQ_W'($urandom_range(FREQ_MAX_HZ, 20'hFFFFF));
  endfunction

  // Mostly short sweeps so the last step and the wrap come often. Bit 19 is
  // beyond the register and must be dropped.
  function automatic logic [FREQ_W-1:0] pick_duration();
    int unsigned r;
    logic [FREQ_W-1:0] d;
    r = $urandom_range(0, 99);
    if (r < 60)      d = FREQ_W'($urandom_range(0, 400));
    else if (r < 90) d = FREQ_W'($urandom_range(400, 3000));
    else             d = FREQ_W'($urandom_range(0, 19'h7FFFF));
    d[FREQ_W-1] = 1'($urandom_range(0, 1));
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int random_ticks;
    int n;
    int restart_pct;

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_START_FREQ;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_restart <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults, with a restart in the middle.
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    stop_ticks();
    wait_drained();

    // Reversed order at the extremes (500000 Hz down to 0 Hz), longest sweep.
    // Run the index up to 12 for the next phase.
    cfg_write(CFG_START_FREQ, FREQ_W'(FREQ_MAX_HZ));
    cfg_write(CFG_STOP_FREQ, '0);
    cfg_write(CFG_DURATION, 20'h7FFFF);
    cfg_release();
    send_tick(1'b1);
    repeat (11) send_tick(1'b0);
    stop_ticks();
    wait_drained();

    // Both ends above the high clamp: flat sweep at the lower end, 600000 Hz.
    // Duration zero (bit 19 set, dropped) clamps to 100 us, 10 steps, so the
    // running index 12 is out of range and reads as step zero. Eleven ticks
    // show the last-step flag and the wrap. The unused index must not land.
    cfg_write(CFG_START_FREQ, 20'hFFFFF);
    cfg_write(CFG_STOP_FREQ, 20'd600000);
    cfg_write(CFG_DURATION, 20'h80000);
    cfg_write(CFG_UNUSED, 20'hFFFFF);
    cfg_release();
    repeat (11) send_tick(1'b0);
    stop_ticks();

    // Random phases: new settings (some registers left alone so the index
    // carries over), then a bursty run of ticks.
    random_ticks = 0;
    while (random_ticks < RANDOM_TICKS) begin
      wait_drained();
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_START_FREQ, pick_freq());
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_STOP_FREQ, pick_freq());
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_DURATION, pick_duration());
      if ($urandom_range(0, 9) == 0)
        cfg_write(CFG_UNUSED, FREQ_W'($urandom_range(0, 20'hFFFFF)));
      cfg_release();
      n = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0:       restart_pct = 0;
        1:       restart_pct = 3;
        default: restart_pct = 20;
      endcase
      run_ticks(n, restart_pct);
      random_ticks += n;
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (sb.pending() > 0)
        $display("%0d steps never came out", sb.pending());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/lcpg_pkg.sv
rtl/core/lcpg_div.sv
rtl/core/lcpg_mul.sv
rtl/core/linear_chirp_period_generator.sv
bench/testbench.sv
